/* hw/rtl/psfcl_pkg.sv */
`default_nettype none

package psfcl_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_CONFIG_LOW   = 3'd0,
    REG_STATUS_POLL  = 3'd1,
    REG_SETTLE       = 3'd2,
    REG_DONE_POLL    = 3'd3,
    REG_RESET_DELAY  = 3'd4,
    REG_RESET_WIDTH  = 3'd5,
    REG_MAX_ATTEMPTS = 3'd6,
    REG_BIT_ORDER    = 3'd7
  } cfg_reg_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned TIMER_W    = 20;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  // Pulses per CONF_DONE burst
  localparam logic [3:0] BURST_DONE_HIGH = 4'd2;
  localparam logic [3:0] BURST_DONE_LOW  = 4'd10;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

  // Reset values of the registers
  localparam logic [15:0] RST_CONFIG_LOW   = 16'd2;
  localparam logic [15:0] RST_STATUS_POLL  = 16'd65535;
  localparam logic [15:0] RST_SETTLE       = 16'd30;
  localparam logic [15:0] RST_DONE_POLL    = 16'd65535;
  localparam logic [15:0] RST_RESET_DELAY  = 16'd710;
  localparam logic [19:0] RST_RESET_WIDTH  = 20'd20000;
  localparam logic [7:0]  RST_MAX_ATTEMPTS = 8'd5;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_CFG_LOW = 4'd1,
    PH_WAIT_ST = 4'd2,
    PH_SETTLE  = 4'd3,
    PH_LOAD    = 4'd4,
    PH_SHIFT   = 4'd5,
    PH_PULSE   = 4'd6,
    PH_RST_DLY = 4'd7,
    PH_RST_LOW = 4'd8,
    PH_DONE    = 4'd9,
    PH_FAILED  = 4'd10
  } phase_t;

  typedef struct packed {
    logic [15:0] config_low_ticks;
    logic [15:0] status_poll_limit;
    logic [15:0] settle_ticks;
    logic [15:0] done_poll_limit;
    logic [15:0] reset_delay_ticks;
    logic [19:0] reset_width_ticks;
    logic [7:0]  max_attempts;
    logic        high_bit_first;
  } cfg_t;

  typedef struct packed {
    logic       start_request;
    logic       nstatus_level;
    logic       done_level;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       byte_last;
  } item_t;

  typedef struct packed {
    logic failed;
    logic done_res;
    logic busy_res;
    logic replay_request;
    logic byte_taken;
    logic user_reset_level;
    logic nconfig_level;
    logic data_level;
    logic dclk_level;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  // Zero counts behave as one
  function automatic logic [15:0] at_least_one16(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [19:0] at_least_one20(input logic [19:0] v);
    return (v == 20'd0) ? 20'd1 : v;
  endfunction

  function automatic logic [7:0] at_least_one8(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/passive_serial_fpga_config_loader.sv */
// Passive-serial configuration master, advanced one tick per input word.
//
// Slave stream: one word per time-base tick carrying the sampled nSTATUS
// and CONF_DONE pins, a start request and an offered bitstream byte (tuser
// flags the byte as offered, tlast marks the final byte). Master stream: one
// word per tick with the pin levels to drive, byte taken, replay request and
// run status. Every input word gives exactly one output word.
//
// Throughput is one word per cycle while the receiver takes words: the
// sequencer step is a single pass of logic between the input register and
// the output register. The output word is registered in the output register
// when its input word steps out of the input register.
//
// When the receiver stalls, the output word holds, the input register fills
// and s_tready drops; the sequencer only advances when a word moves into the
// output register, so no tick is lost or repeated.
//
// Reset (rst, synchronous) empties both registers, returns the sequencer to
// idle with nCONFIG and user reset high, and loads the default register set.
// The user must write registers through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
`default_nettype none

module passive_serial_fpga_config_loader (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // start_request, nstatus_level, done_level, byte_value[7:0], zero fill
  input  wire logic [psfcl_pkg::IN_DATA_W-1:0]   s_tdata,
  // byte_valid
  input  wire logic                             s_tuser,
  input  wire logic                             s_tlast,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // dclk_level, data_level, nconfig_level, user_reset_level, byte_taken,
  // replay_request, busy_res, done_res, failed, zero fill
  output logic [psfcl_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic                             cfg_we,
  input  wire logic [psfcl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [psfcl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psfcl_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    step;
  result_t result;

  // Move a word into the output register when it is free or being taken
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  psfcl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.start_request <= s_tdata[0];
      in_item.nstatus_level <= s_tdata[1];
      in_item.done_level    <= s_tdata[2];
      in_item.byte_value    <= s_tdata[10:3];
      in_item.byte_valid    <= s_tuser;
      in_item.byte_last     <= s_tlast;
    end
  end

  psfcl_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= OUT_DATA_W'(result);
    end
  end

  // A retry only starts inside a run
  a_replay_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[6])
    else $error("replay request outside a run");

  // A byte is only taken while nCONFIG is released inside a run
  a_taken_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[6] && m_tdata[2])
    else $error("byte taken outside the shift phase");

  // Done and failed exclude each other and exclude busy
  a_status_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tdata[8:6]) <= 1)
    else $error("conflicting run status");

  // nCONFIG is only pulled low during a run
  a_ncfg_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[6])
    else $error("nCONFIG low while idle");

  // A word that steps out of the input register is always valid in the output register the cycle after
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("word lost between stages");

endmodule

`default_nettype wire

/* hw/rtl/psfcl_cfg.sv */
`default_nettype none

module psfcl_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [psfcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [psfcl_pkg::CFG_DATA_W-1:0] cfg_data,
  output psfcl_pkg::cfg_t                      cfg
);
  import psfcl_pkg::*;

  cfg_t cfg_regs;

  assign cfg = cfg_regs;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.config_low_ticks  <= RST_CONFIG_LOW;
      cfg_regs.status_poll_limit <= RST_STATUS_POLL;
      cfg_regs.settle_ticks      <= RST_SETTLE;
      cfg_regs.done_poll_limit   <= RST_DONE_POLL;
      cfg_regs.reset_delay_ticks <= RST_RESET_DELAY;
      cfg_regs.reset_width_ticks <= RST_RESET_WIDTH;
      cfg_regs.max_attempts      <= RST_MAX_ATTEMPTS;
      cfg_regs.high_bit_first    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CONFIG_LOW:   cfg_regs.config_low_ticks  <= cfg_data[15:0];
        REG_STATUS_POLL:  cfg_regs.status_poll_limit <= cfg_data[15:0];
        REG_SETTLE:       cfg_regs.settle_ticks      <= cfg_data[15:0];
        REG_DONE_POLL:    cfg_regs.done_poll_limit   <= cfg_data[15:0];
        REG_RESET_DELAY:  cfg_regs.reset_delay_ticks <= cfg_data[15:0];
        REG_RESET_WIDTH:  cfg_regs.reset_width_ticks <= cfg_data[19:0];
        REG_MAX_ATTEMPTS: cfg_regs.max_attempts      <= cfg_data[7:0];
        REG_BIT_ORDER:    cfg_regs.high_bit_first    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/psfcl_core.sv */
`default_nettype none

module psfcl_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  psfcl_pkg::item_t    item,
  input  psfcl_pkg::cfg_t     cfg,
  output psfcl_pkg::result_t  result
);
  import psfcl_pkg::*;

  phase_t               phase, phase_next;
  logic [7:0]           attempts_left, attempts_left_next;
  logic [TIMER_W-1:0]   tick_timer, tick_timer_next;
  logic [15:0]          poll_count, poll_count_next;
  logic [7:0]           shift_byte, shift_byte_next;
  logic [3:0]           bit_count, bit_count_next;
  logic                 half_clock, half_clock_next;
  logic [3:0]           pulse_count, pulse_count_next;
  logic                 last_seen, last_seen_next;
  logic                 pin_dclk, pin_dclk_next;
  logic                 pin_data, pin_data_next;
  logic                 pin_ncfg, pin_ncfg_next;
  logic                 pin_urst, pin_urst_next;

  logic                 taken;
  logic                 replay;
  logic                 fail_hit;
  logic                 start_hit;
  logic                 put_hit;
  logic [7:0]           put_src;
  logic [15:0]          poll_inc;
  logic [3:0]           bit_inc;
  logic [3:0]           pulse_dec;
  logic [TIMER_W-1:0]   timer_dec;

  assign poll_inc  = poll_count + 16'd1;
  assign bit_inc   = bit_count + 4'd1;
  assign pulse_dec = pulse_count - 4'd1;
  assign timer_dec = tick_timer - TIMER_W'(1);

  // Advance the sequencer by one tick
  always_comb begin
    phase_next         = phase;
    attempts_left_next = attempts_left;
    tick_timer_next    = tick_timer;
    poll_count_next    = poll_count;
    shift_byte_next    = shift_byte;
    bit_count_next     = bit_count;
    half_clock_next    = half_clock;
    pulse_count_next   = pulse_count;
    last_seen_next     = last_seen;
    pin_dclk_next      = pin_dclk;
    pin_data_next      = pin_data;
    pin_ncfg_next      = pin_ncfg;
    pin_urst_next      = pin_urst;
    taken              = 1'b0;
    replay             = 1'b0;
    fail_hit           = 1'b0;
    start_hit          = 1'b0;
    put_hit            = 1'b0;
    put_src            = shift_byte;

    unique case (phase)
      PH_CFG_LOW: begin
        if (tick_timer == '0) begin
          pin_ncfg_next   = 1'b1;
          poll_count_next = 16'd0;
          phase_next      = PH_WAIT_ST;
        end else begin
          tick_timer_next = timer_dec;
        end
      end
      PH_WAIT_ST: begin
        if (item.nstatus_level) begin
          if (cfg.settle_ticks == 16'd0) begin
            phase_next = PH_LOAD;
          end else begin
            tick_timer_next = TIMER_W'(cfg.settle_ticks);
            phase_next      = PH_SETTLE;
          end
        end else begin
          poll_count_next = poll_inc;
          fail_hit        = (poll_inc >= at_least_one16(cfg.status_poll_limit));
        end
      end
      PH_SETTLE: begin
        tick_timer_next = timer_dec;
        if (timer_dec == '0) phase_next = PH_LOAD;
      end
      PH_LOAD: begin
        if (item.byte_valid) begin
          taken          = 1'b1;
          put_hit        = 1'b1;
          put_src        = item.byte_value;
          last_seen_next = item.byte_last;
          bit_count_next = 4'd0;
          phase_next     = PH_SHIFT;
        end
      end
      PH_SHIFT: begin
        if (!half_clock) begin
          pin_dclk_next   = 1'b1;
          half_clock_next = 1'b1;
        end else begin
          bit_count_next = bit_inc;
          if (bit_inc < BITS_PER_BYTE) begin
            put_hit = 1'b1;
          end else if (last_seen) begin
            pin_dclk_next    = 1'b0;
            pin_data_next    = 1'b0;
            half_clock_next  = 1'b0;
            poll_count_next  = 16'd0;
            pulse_count_next = item.done_level ? BURST_DONE_HIGH : BURST_DONE_LOW;
            phase_next       = PH_PULSE;
          end else if (item.byte_valid) begin
            taken          = 1'b1;
            put_hit        = 1'b1;
            put_src        = item.byte_value;
            last_seen_next = item.byte_last;
            bit_count_next = 4'd0;
          end else begin
            pin_dclk_next   = 1'b0;
            half_clock_next = 1'b0;
            phase_next      = PH_LOAD;
          end
        end
      end
      PH_PULSE: begin
        if (!half_clock) begin
          pin_dclk_next   = 1'b1;
          half_clock_next = 1'b1;
        end else begin
          pin_dclk_next    = 1'b0;
          half_clock_next  = 1'b0;
          pulse_count_next = pulse_dec;
          if (pulse_dec == 4'd0) begin
            if (item.done_level) begin
              if (cfg.reset_delay_ticks == 16'd0) begin
                pin_urst_next   = 1'b0;
                tick_timer_next = at_least_one20(cfg.reset_width_ticks) - 20'd1;
                phase_next      = PH_RST_LOW;
              end else begin
                tick_timer_next = TIMER_W'(cfg.reset_delay_ticks);
                phase_next      = PH_RST_DLY;
              end
            end else begin
              poll_count_next = poll_inc;
              if (poll_inc >= at_least_one16(cfg.done_poll_limit)) begin
                fail_hit = 1'b1;
              end else begin
                pulse_count_next = BURST_DONE_LOW;
              end
            end
          end
        end
      end
      PH_RST_DLY: begin
        tick_timer_next = timer_dec;
        if (timer_dec == '0) begin
          pin_urst_next   = 1'b0;
          tick_timer_next = at_least_one20(cfg.reset_width_ticks) - 20'd1;
          phase_next      = PH_RST_LOW;
        end
      end
      PH_RST_LOW: begin
        if (tick_timer == '0) begin
          pin_urst_next = 1'b1;
          phase_next    = PH_DONE;
        end else begin
          tick_timer_next = timer_dec;
        end
      end
      PH_IDLE, PH_DONE, PH_FAILED: begin
        if (item.start_request) begin
          attempts_left_next = at_least_one8(cfg.max_attempts) - 8'd1;
          start_hit          = 1'b1;
        end
      end
      default: begin
        phase_next    = PH_IDLE;
        pin_dclk_next = 1'b0;
        pin_data_next = 1'b0;
        pin_ncfg_next = 1'b1;
        pin_urst_next = 1'b1;
      end
    endcase

    // Drive the next data bit, clock low
    if (put_hit) begin
      pin_data_next   = cfg.high_bit_first ? put_src[7] : put_src[0];
      shift_byte_next = cfg.high_bit_first ? {put_src[6:0], 1'b0} : {1'b0, put_src[7:1]};
      pin_dclk_next   = 1'b0;
      half_clock_next = 1'b0;
    end

    // Retry or give up after a timeout
    if (fail_hit) begin
      if (attempts_left == 8'd0) begin
        pin_dclk_next = 1'b0;
        pin_data_next = 1'b0;
        pin_ncfg_next = 1'b1;
        pin_urst_next = 1'b1;
        phase_next    = PH_FAILED;
      end else begin
        attempts_left_next = attempts_left - 8'd1;
        replay             = 1'b1;
        start_hit          = 1'b1;
      end
    end

    // Open an attempt: pull nCONFIG low
    if (start_hit) begin
      pin_dclk_next   = 1'b0;
      pin_data_next   = 1'b0;
      pin_ncfg_next   = 1'b0;
      pin_urst_next   = 1'b1;
      half_clock_next = 1'b0;
      poll_count_next = 16'd0;
      tick_timer_next = TIMER_W'(at_least_one16(cfg.config_low_ticks) - 16'd1);
      phase_next      = PH_CFG_LOW;
    end
  end

  // Result of this tick, from the updated state
  always_comb begin
    result.dclk_level       = pin_dclk_next;
    result.data_level       = pin_data_next;
    result.nconfig_level    = pin_ncfg_next;
    result.user_reset_level = pin_urst_next;
    result.byte_taken       = taken;
    result.replay_request   = replay;
    result.busy_res         = (phase_next != PH_IDLE) && (phase_next != PH_DONE) &&
                              (phase_next != PH_FAILED);
    result.done_res         = (phase_next == PH_DONE);
    result.failed           = (phase_next == PH_FAILED);
  end

  // Hold state between ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      attempts_left <= 8'd0;
      tick_timer    <= '0;
      poll_count    <= 16'd0;
      shift_byte    <= 8'd0;
      bit_count     <= 4'd0;
      half_clock    <= 1'b0;
      pulse_count   <= 4'd0;
      last_seen     <= 1'b0;
      pin_dclk      <= 1'b0;
      pin_data      <= 1'b0;
      pin_ncfg      <= 1'b1;
      pin_urst      <= 1'b1;
    end else if (step) begin
      phase         <= phase_next;
      attempts_left <= attempts_left_next;
      tick_timer    <= tick_timer_next;
      poll_count    <= poll_count_next;
      shift_byte    <= shift_byte_next;
      bit_count     <= bit_count_next;
      half_clock    <= half_clock_next;
      pulse_count   <= pulse_count_next;
      last_seen     <= last_seen_next;
      pin_dclk      <= pin_dclk_next;
      pin_data      <= pin_data_next;
      pin_ncfg      <= pin_ncfg_next;
      pin_urst      <= pin_urst_next;
    end
  end

endmodule

`default_nettype wire
